// ===== rtl/bq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bq_pkg: shared types, constants and rounding functions
// Common definitions for the multichannel transposed direct form II biquad.
// ----------------------------------------------------------------------------
package bq_pkg;

    localparam int CHANNELS_DEFAULT = 8;
    localparam int CHAN_W   = 3;
    localparam int SAMPLE_W = 24;
    localparam int COEF_W   = 32;
    localparam int STATE_W  = 48;
    localparam int PROD_W   = COEF_W + SAMPLE_W;
    localparam int ACC_W    = 64;
    localparam int STATE_SHIFT = 14;
    localparam int Y_SHIFT     = 30;
    localparam int CFG_ADDR_W  = 3;

    localparam logic [COEF_W-1:0] COEF_B0_RESET = 32'h4000_0000;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_B0 = 3'd0,
        REG_B1 = 3'd1,
        REG_B2 = 3'd2,
        REG_A1 = 3'd3,
        REG_A2 = 3'd4
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_B0,
        ST_SUM_Y,
        ST_ROUND_Y,
        ST_MUL_A1,
        ST_SUB_A1,
        ST_WR_ONE,
        ST_SUB_A2,
        ST_WR_TWO
    } state_t;

    typedef enum logic [2:0] {
        CSEL_B0,
        CSEL_B1,
        CSEL_B2,
        CSEL_A1,
        CSEL_A2
    } coef_sel_t;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD_S1,
        ACC_LOAD_S2,
        ACC_LOAD_P,
        ACC_SUB
    } acc_op_t;

    typedef struct packed {
        logic      in_load;
        logic      mul_en;
        coef_sel_t coef_sel;
        logic      use_y;
        acc_op_t   acc_op;
        logic      y_load;
        logic      wr_one;
        logic      wr_two;
        logic      out_load;
    } cmd_t;

    function automatic logic [SAMPLE_W:0] round_sat_y(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] t;
        logic signed [ACC_W-1:0] q;
        logic [SAMPLE_W:0]       r;
        t = acc + (64'sd1 <<< (Y_SHIFT - 1));
        q = t >>> Y_SHIFT;
        if (q > 64'sd8388607) begin
            r = {1'b1, 24'h7F_FFFF};
        end
        else if (q < -64'sd8388608) begin
            r = {1'b1, 24'h80_0000};
        end
        else begin
            r = {1'b0, q[SAMPLE_W-1:0]};
        end
        return r;
    endfunction

    function automatic logic [STATE_W-1:0] round_sat_state(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] t;
        logic signed [ACC_W-1:0] q;
        logic [STATE_W-1:0]      r;
        t = acc + (64'sd1 <<< (STATE_SHIFT - 1));
        q = t >>> STATE_SHIFT;
        if (q > 64'sd140737488355327) begin
            r = 48'h7FFF_FFFF_FFFF;
        end
        else if (q < -64'sd140737488355328) begin
            r = 48'h8000_0000_0000;
        end
        else begin
            r = q[STATE_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/biquad_tdf2_multichannel.sv =====
// One sample is processed at a time, with the single shared 32 x 24
// multiplier forming all five products in turn with one accumulator; a new
// sample is accepted only when the sequencer has returned to idle.
// A new sample is taken while the previous result still waits at the output.
// Reset is asynchronous and active low; it loads b0 = 1.0 with the other
// coefficients at zero and clears the valid bits, so delay state reads as zero.
`default_nettype none
// ----------------------------------------------------------------------------
// biquad_tdf2_multichannel: multichannel transposed direct form II biquad
// Filters channel-tagged Q0.23 samples with Q2.30 coefficients, keeping a
// separate pair of delay states for each channel.
// ----------------------------------------------------------------------------
module biquad_tdf2_multichannel
    import bq_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEFAULT
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [COEF_W-1:0]     cfg_wdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [SAMPLE_W-1:0]   s_tdata,   // [23:0] sample_in
    input  wire logic [CHAN_W-1:0]     s_tuser,   // [2:0] chan
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [SAMPLE_W-1:0]        m_tdata,   // [23:0] sample_out
    output logic [3:0]                 m_tuser    // [2:0] chan_out, [3] clipped
);

    cmd_t                       cmd;
    logic [CHAN_W-1:0]          chan_out;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       clipped;

    bq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    bq_dp #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .cmd        (cmd),
        .chan       (s_tuser),
        .sample_in  ($signed(s_tdata)),
        .chan_out   (chan_out),
        .sample_out (sample_out),
        .clipped    (clipped)
    );

    assign m_tdata = sample_out;
    assign m_tuser = {clipped, chan_out};

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("Sample accepted while another is in progress.");

    a_busy_two: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |-> ##2 !s_tready)
        else $error("Sequencer returned to idle too early.");

    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("Result appeared without a sample in progress.");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !(cmd.wr_one || cmd.wr_two || cmd.out_load))
        else $error("State written while the sequencer is idle.");
`endif

endmodule
`default_nettype wire

// ===== rtl/bq_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bq_ctrl: sequencer for one biquad sample
// Steps the shared multiplier and accumulator through the five products and
// owns the stream handshakes.
// ----------------------------------------------------------------------------
module bq_ctrl
    import bq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  wire logic m_tready,
    output cmd_t      cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        cmd          = '0;
        cmd.coef_sel = CSEL_B0;
        cmd.acc_op   = ACC_HOLD;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.in_load = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = ST_MUL_B0;
                end
            end
            ST_MUL_B0:
            begin
                cmd.mul_en = 1'b1;
                state_next = ST_SUM_Y;
            end
            ST_SUM_Y:
            begin
                cmd.mul_en   = 1'b1;
                cmd.coef_sel = CSEL_B1;
                cmd.acc_op   = ACC_LOAD_S1;
                state_next   = ST_ROUND_Y;
            end
            ST_ROUND_Y:
            begin
                cmd.y_load = 1'b1;
                cmd.acc_op = ACC_LOAD_S2;
                state_next = ST_MUL_A1;
            end
            ST_MUL_A1:
            begin
                cmd.mul_en   = 1'b1;
                cmd.coef_sel = CSEL_A1;
                cmd.use_y    = 1'b1;
                state_next   = ST_SUB_A1;
            end
            ST_SUB_A1:
            begin
                cmd.mul_en   = 1'b1;
                cmd.coef_sel = CSEL_B2;
                cmd.acc_op   = ACC_SUB;
                state_next   = ST_WR_ONE;
            end
            ST_WR_ONE:
            begin
                cmd.wr_one   = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.coef_sel = CSEL_A2;
                cmd.use_y    = 1'b1;
                cmd.acc_op   = ACC_LOAD_P;
                state_next   = ST_SUB_A2;
            end
            ST_SUB_A2:
            begin
                cmd.acc_op = ACC_SUB;
                state_next = ST_WR_TWO;
            end
            ST_WR_TWO:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.wr_two   = 1'b1;
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule
`default_nettype wire

// ===== rtl/bq_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bq_dp: biquad datapath
// Coefficient registers, per-channel delay memories, one shared multiplier,
// the accumulator with rounding and saturation, and the result register.
// ----------------------------------------------------------------------------
module bq_dp
    import bq_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEFAULT
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]      cfg_addr,
    input  wire logic [COEF_W-1:0]          cfg_wdata,
    input  wire cmd_t                       cmd,
    input  wire logic [CHAN_W-1:0]          chan,
    input  wire logic signed [SAMPLE_W-1:0] sample_in,
    output logic [CHAN_W-1:0]               chan_out,
    output logic signed [SAMPLE_W-1:0]      sample_out,
    output logic                            clipped
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic signed [COEF_W-1:0] b0_reg, b1_reg, b2_reg, a1_reg, a2_reg;

    logic [STATE_W-1:0] one_mem [CHANNELS];
    logic [STATE_W-1:0] two_mem [CHANNELS];
    logic [CHANNELS-1:0] valid_reg;

    logic [CHAN_W-1:0]          chan_reg;
    logic [IDX_W-1:0]           idx_reg;
    logic                       ok_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [SAMPLE_W-1:0] y_reg;
    logic                       clip_reg;
    logic [STATE_W-1:0]         one_rd_reg, two_rd_reg;
    logic                       rd_ok_reg;

    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;

    logic signed [COEF_W-1:0]   mul_a;
    logic signed [SAMPLE_W-1:0] mul_b;
    logic [IDX_W-1:0]           in_idx;
    logic                       in_ok;
    logic signed [STATE_W-1:0]  s1, s2;
    logic signed [ACC_W-1:0]    prod_ext, s1_ext, s2_ext;
    logic [SAMPLE_W:0]          y_rs;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_reg <= COEF_B0_RESET;
            b1_reg <= '0;
            b2_reg <= '0;
            a1_reg <= '0;
            a2_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_B0:  b0_reg <= cfg_wdata;
                REG_B1:  b1_reg <= cfg_wdata;
                REG_B2:  b2_reg <= cfg_wdata;
                REG_A1:  a1_reg <= cfg_wdata;
                REG_A2:  a2_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign in_idx = IDX_W'(chan);
    assign in_ok  = (32'(chan) < CHANNELS);

    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            chan_reg   <= chan;
            idx_reg    <= in_idx;
            ok_reg     <= in_ok;
            x_reg      <= sample_in;
            one_rd_reg <= one_mem[in_idx];
            two_rd_reg <= two_mem[in_idx];
            rd_ok_reg  <= in_ok && valid_reg[in_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_one && ok_reg)
        begin
            one_mem[idx_reg] <= round_sat_state(acc_reg);
        end
        if (cmd.wr_two && ok_reg)
        begin
            two_mem[idx_reg] <= round_sat_state(acc_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.wr_two && ok_reg)
        begin
            valid_reg[idx_reg] <= 1'b1;
        end
    end

    always_comb
    begin
        case (cmd.coef_sel)
            CSEL_B0: mul_a = b0_reg;
            CSEL_B1: mul_a = b1_reg;
            CSEL_B2: mul_a = b2_reg;
            CSEL_A1: mul_a = a1_reg;
            CSEL_A2: mul_a = a2_reg;
            default: mul_a = '0;
        endcase
    end

    assign mul_b = cmd.use_y ? y_reg : x_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg <= mul_a * mul_b;
        end
    end

    assign s1       = rd_ok_reg ? $signed(one_rd_reg) : '0;
    assign s2       = rd_ok_reg ? $signed(two_rd_reg) : '0;
    assign prod_ext = ACC_W'(prod_reg);
    assign s1_ext   = {{(ACC_W - STATE_W - STATE_SHIFT){s1[STATE_W-1]}}, s1,
                       {STATE_SHIFT{1'b0}}};
    assign s2_ext   = {{(ACC_W - STATE_W - STATE_SHIFT){s2[STATE_W-1]}}, s2,
                       {STATE_SHIFT{1'b0}}};

    always_comb
    begin
        case (cmd.acc_op)
            ACC_HOLD:    acc_next = acc_reg;
            ACC_LOAD_S1: acc_next = prod_ext + s1_ext;
            ACC_LOAD_S2: acc_next = prod_ext + s2_ext;
            ACC_LOAD_P:  acc_next = prod_ext;
            ACC_SUB:     acc_next = acc_reg - prod_ext;
            default:     acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign y_rs = round_sat_y(acc_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.y_load)
        begin
            y_reg    <= $signed(y_rs[SAMPLE_W-1:0]);
            clip_reg <= y_rs[SAMPLE_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            chan_out   <= chan_reg;
            sample_out <= y_reg;
            clipped    <= clip_reg;
        end
    end

endmodule
`default_nettype wire
